FILE: src/abd_pkg.sv
// Shared types, constants and coefficient tables for the ADPCM block decoder.
package abd_pkg;

   localparam int unsigned POS_W    = 4;
   localparam int unsigned SAMPLE_W = 16;
   localparam int unsigned COEF_W   = 8;

   localparam logic [POS_W-1:0] POS_HEADER = 4'd0;
   localparam logic [POS_W-1:0] POS_FLAGS  = 4'd1;

   localparam logic [3:0] BIG_SHIFT  = 4'd12;
   localparam logic [2:0] FILTER_MAX = 3'd4;

   localparam logic signed [20:0] SAT_MAX = 21'sd32767;
   localparam logic signed [20:0] SAT_MIN = -21'sd32768;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [COEF_W-1:0]   coef_type;

   typedef struct packed {
      logic [3:0] shift;
      logic [2:0] filter;
   } blk_hdr_type;

   // Weight of the newest sample, per filter
   function automatic coef_type coef_a(input logic [2:0] filter);
      coef_type k;
      case (filter)
         3'd0:    k = 8'sd0;
         3'd1:    k = 8'sd60;
         3'd2:    k = 8'sd115;
         3'd3:    k = 8'sd98;
         default: k = 8'sd122;
      endcase
      return k;
   endfunction

   // Weight of the older sample, per filter
   function automatic coef_type coef_b(input logic [2:0] filter);
      coef_type k;
      case (filter)
         3'd0:    k = 8'sd0;
         3'd1:    k = 8'sd0;
         3'd2:    k = -8'sd52;
         3'd3:    k = -8'sd55;
         default: k = -8'sd60;
      endcase
      return k;
   endfunction

endpackage

FILE: src/abd_if.sv
// Valid/ready channel interfaces for the byte input and the sample output.
interface abd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       stream_start;

   modport source (output valid, output data_byte, output stream_start, input ready);
   modport sink   (input valid, input data_byte, input stream_start, output ready);
endinterface

interface abd_rsp_if;
   logic                valid;
   logic                ready;
   abd_pkg::sample_type sample;
   logic                last_of_byte;

   modport source (output valid, output sample, output last_of_byte, input ready);
   modport sink   (input valid, input sample, input last_of_byte, output ready);
endinterface

FILE: src/abd_nib_dec.sv
// Single-nibble decoder: scale, shift, add the filtered prediction, saturate.
module abd_nib_dec (
   input  logic [3:0]           nibble,
   input  abd_pkg::blk_hdr_type hdr,
   input  abd_pkg::sample_type  hist_one,
   input  abd_pkg::sample_type  hist_two,
   output abd_pkg::sample_type  sample
);

   logic signed [15:0] scaled;
   logic signed [15:0] shifted;
   abd_pkg::coef_type  k_a;
   abd_pkg::coef_type  k_b;
   logic signed [23:0] prod_a;
   logic signed [23:0] prod_b;
   logic signed [25:0] pred_sum;
   logic signed [19:0] pred;
   logic signed [20:0] total;

   always_comb begin
      scaled = $signed({nibble, 12'b0});
      // large shifts leave only the sign
      if (hdr.shift > abd_pkg::BIG_SHIFT) begin
         shifted = {16{nibble[3]}};
      end else begin
         shifted = scaled >>> hdr.shift;
      end
      k_a      = abd_pkg::coef_a(hdr.filter);
      k_b      = abd_pkg::coef_b(hdr.filter);
      prod_a   = hist_one * k_a;
      prod_b   = hist_two * k_b;
      pred_sum = 26'(prod_a) + 26'(prod_b) + 26'sd32;
      pred     = 20'(pred_sum >>> 6);
      total    = 21'(shifted) + 21'(pred);
      if (total > abd_pkg::SAT_MAX) begin
         sample = 16'sh7FFF;
      end else if (total < abd_pkg::SAT_MIN) begin
         sample = -16'sh8000;
      end else begin
         sample = 16'(total);
      end
   end

endmodule

FILE: src/abd_out_stage.sv
// Output register for decoded samples, loadable whenever empty or being drained.
module abd_out_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  abd_pkg::sample_type load_sample,
   input  logic                load_last,
   output logic                can_load,
   abd_rsp_if.source           rsp_ch
);

   logic                valid_ff;
   logic                valid_in;
   abd_pkg::sample_type sample_ff;
   logic                last_ff;

   assign can_load = !valid_ff || rsp_ch.ready;
   assign valid_in = load || (valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         sample_ff <= load_sample;
         last_ff   <= load_last;
      end
   end

   assign rsp_ch.valid        = valid_ff;
   assign rsp_ch.sample       = sample_ff;
   assign rsp_ch.last_of_byte = last_ff;

endmodule

FILE: src/adpcm_block_decoder.sv
// ADPCM block decoder: 16-byte blocks in, two 16-bit samples per data byte out.
// Each accepted byte sits in one input register. Header and flags bytes leave
// it without waiting on the output; each data byte stays there for both nibbles,
// since the single nibble decoder feeds its result back as history for the next
// nibble. An unstalled 16-byte block therefore yields 28 samples at one per
// cycle; a sample is registered in the output stage and appears there in the
// cycle after its nibble is decoded. A new byte is taken in the cycle its predecessor finishes.
module adpcm_block_decoder (
   input  logic      clock,
   input  logic      reset,
   abd_req_if.sink   req_ch,
   abd_rsp_if.source rsp_ch
);

   logic                           hold_valid_ff, hold_valid_in;
   logic [7:0]                     hold_byte_ff;
   logic                           hold_start_ff;
   logic                           phase_ff, phase_in;
   logic [abd_pkg::POS_W-1:0]      pos_ff, pos_in;
   abd_pkg::blk_hdr_type           hdr_ff, hdr_in;
   abd_pkg::sample_type            hist_one_ff, hist_one_in;
   abd_pkg::sample_type            hist_two_ff, hist_two_in;

   logic [abd_pkg::POS_W-1:0]      pos_cur;
   logic                           is_header;
   logic                           is_data;
   logic [3:0]                     nibble;
   abd_pkg::sample_type            dec_sample;
   logic                           out_can_load;
   logic                           emit;
   logic                           hold_done;
   logic                           accept;

   // stream start always restarts the block at the header
   assign pos_cur   = hold_start_ff ? abd_pkg::POS_HEADER : pos_ff;
   assign is_header = (pos_cur == abd_pkg::POS_HEADER);
   assign is_data   = !is_header && (pos_cur != abd_pkg::POS_FLAGS);
   assign nibble    = phase_ff ? hold_byte_ff[7:4] : hold_byte_ff[3:0];

   assign emit      = hold_valid_ff && is_data && out_can_load;
   assign hold_done = hold_valid_ff && (!is_data || (emit && phase_ff));
   assign accept    = req_ch.valid && req_ch.ready;

   assign req_ch.ready = !hold_valid_ff || hold_done;

   abd_nib_dec u_nib_dec (
      .nibble   (nibble),
      .hdr      (hdr_ff),
      .hist_one (hist_one_ff),
      .hist_two (hist_two_ff),
      .sample   (dec_sample)
   );

   abd_out_stage u_out_stage (
      .clock       (clock),
      .reset       (reset),
      .load        (emit),
      .load_sample (dec_sample),
      .load_last   (phase_ff),
      .can_load    (out_can_load),
      .rsp_ch      (rsp_ch)
   );

   always_comb begin
      hold_valid_in = accept || (hold_valid_ff && !hold_done);
      phase_in      = phase_ff;
      pos_in        = pos_ff;
      hdr_in        = hdr_ff;
      hist_one_in   = hist_one_ff;
      hist_two_in   = hist_two_ff;
      if (hold_done) begin
         pos_in = pos_cur + 4'd1;
      end
      if (hold_valid_ff && is_header) begin
         hdr_in.shift  = hold_byte_ff[3:0];
         hdr_in.filter = (hold_byte_ff[6:4] > abd_pkg::FILTER_MAX) ?
                         abd_pkg::FILTER_MAX : hold_byte_ff[6:4];
         if (hold_start_ff) begin
            hist_one_in = '0;
            hist_two_in = '0;
         end
      end
      if (emit) begin
         hist_two_in = hist_one_ff;
         hist_one_in = dec_sample;
         phase_in    = !phase_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         phase_ff      <= 1'b0;
         pos_ff        <= abd_pkg::POS_HEADER;
         hdr_ff        <= '0;
         hist_one_ff   <= '0;
         hist_two_ff   <= '0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         phase_ff      <= phase_in;
         pos_ff        <= pos_in;
         hdr_ff        <= hdr_in;
         hist_one_ff   <= hist_one_in;
         hist_two_ff   <= hist_two_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hold_byte_ff  <= req_ch.data_byte;
         hold_start_ff <= req_ch.stream_start;
      end
   end

`ifndef NO_ASSERTIONS
   a_filter_limited: assert property (@(posedge clock) disable iff (reset)
      hdr_ff.filter <= abd_pkg::FILTER_MAX)
      else $error("latched filter beyond the last table entry");

   a_phase_on_data: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> (pos_ff != abd_pkg::POS_HEADER && pos_ff != abd_pkg::POS_FLAGS))
      else $error("second nibble pending outside the data bytes");

   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      (hold_done && is_header && hold_start_ff) |=>
      (hist_one_ff == '0 && hist_two_ff == '0 && pos_ff == abd_pkg::POS_FLAGS))
      else $error("stream start did not clear history");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      emit |=> (rsp_ch.valid && rsp_ch.last_of_byte == $past(phase_ff)))
      else $error("sample order flag does not follow the nibble");
`endif

endmodule
